// ===== src/rqy_pkg.sv =====
`default_nettype none

package rqy_pkg;

  localparam int unsigned CompW = 8;

  // limited range limits
  localparam logic [CompW-1:0] LumaMin   = 8'd16;
  localparam logic [CompW-1:0] LumaMax   = 8'd235;
  localparam logic [CompW-1:0] ChromaMin = 8'd16;
  localparam logic [CompW-1:0] ChromaMax = 8'd240;

  typedef logic [CompW-1:0] comp_t;

  typedef struct packed {
    comp_t red_top_left;
    comp_t green_top_left;
    comp_t blue_top_left;
    comp_t red_top_right;
    comp_t green_top_right;
    comp_t blue_top_right;
    comp_t red_bottom_left;
    comp_t green_bottom_left;
    comp_t blue_bottom_left;
    comp_t red_bottom_right;
    comp_t green_bottom_right;
    comp_t blue_bottom_right;
  } quad_t;

  typedef struct packed {
    comp_t luma_top_left;
    comp_t luma_top_right;
    comp_t luma_bottom_left;
    comp_t luma_bottom_right;
    comp_t chroma_blue;
    comp_t chroma_red;
  } yuv_t;

  // load strobes of the three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== src/rqy_quad_if.sv =====
`default_nettype none

interface rqy_quad_if;
  logic          valid;
  logic          ready;
  rqy_pkg::quad_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rqy_yuv_if.sv =====
`default_nettype none

interface rqy_yuv_if;
  logic         valid;
  logic         ready;
  rqy_pkg::yuv_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rqy_luma_lane.sv =====
`default_nettype none

module rqy_luma_lane (
  input  wire logic               clk_i,
  input  wire rqy_pkg::stage_en_t en_i,
  input  wire rqy_pkg::comp_t     red_i,
  input  wire rqy_pkg::comp_t     green_i,
  input  wire rqy_pkg::comp_t     blue_i,
  output rqy_pkg::comp_t          luma_o
);

  logic [15:0]    num_d, num_q;
  logic [8:0]     raw;
  rqy_pkg::comp_t luma_d, luma_q;
  rqy_pkg::comp_t out_q;

  // weighted sum with rounding offset, peaks at 56228
  assign num_d = 16'(red_i) * 16'd66 + 16'(green_i) * 16'd129
               + 16'(blue_i) * 16'd25 + 16'd128;

  assign raw = {1'b0, num_q[15:8]} + 9'(rqy_pkg::LumaMin);

  always_comb begin
    if (raw < 9'(rqy_pkg::LumaMin)) begin
      luma_d = rqy_pkg::LumaMin;
    end else if (raw > 9'(rqy_pkg::LumaMax)) begin
      luma_d = rqy_pkg::LumaMax;
    end else begin
      luma_d = raw[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) num_q  <= num_d;
    if (en_i.s2) luma_q <= luma_d;
    if (en_i.s3) out_q  <= luma_q;
  end

  assign luma_o = out_q;

endmodule

`default_nettype wire

// ===== src/rqy_chroma.sv =====
`default_nettype none

module rqy_chroma (
  input  wire logic               clk_i,
  input  wire rqy_pkg::stage_en_t en_i,
  input  wire rqy_pkg::quad_t     quad_i,
  output rqy_pkg::comp_t          chroma_blue_o,
  output rqy_pkg::comp_t          chroma_red_o
);

  logic [9:0]         rsum, gsum, bsum;
  rqy_pkg::comp_t     ravg_q, gavg_q, bavg_q;
  logic signed [16:0] rr, gg, bb;
  logic signed [16:0] cb_full, cr_full;
  logic signed [15:0] cb_num_q, cr_num_q;
  rqy_pkg::comp_t     cb_d, cr_d, cb_q, cr_q;

  assign rsum = 10'(quad_i.red_top_left) + 10'(quad_i.red_top_right)
              + 10'(quad_i.red_bottom_left) + 10'(quad_i.red_bottom_right);
  assign gsum = 10'(quad_i.green_top_left) + 10'(quad_i.green_top_right)
              + 10'(quad_i.green_bottom_left) + 10'(quad_i.green_bottom_right);
  assign bsum = 10'(quad_i.blue_top_left) + 10'(quad_i.blue_top_right)
              + 10'(quad_i.blue_bottom_left) + 10'(quad_i.blue_bottom_right);

  assign rr = $signed({9'b0, ravg_q});
  assign gg = $signed({9'b0, gavg_q});
  assign bb = $signed({9'b0, bavg_q});

  // numerators stay within -28432..28688
  assign cb_full = 17'sd112 * bb - 17'sd38 * rr - 17'sd74 * gg + 17'sd128;
  assign cr_full = 17'sd112 * rr - 17'sd94 * gg - 17'sd18 * bb + 17'sd128;

  function automatic rqy_pkg::comp_t finish(input logic signed [15:0] num);
    logic signed [15:0] adj;
    logic signed [9:0]  val;
    begin
      // divide by 256 rounding toward zero
      adj = num[15] ? num + 16'sd255 : num;
      val = 10'(adj >>> 8) + 10'sd128;
      if (val < $signed({2'b00, rqy_pkg::ChromaMin})) begin
        finish = rqy_pkg::ChromaMin;
      end else if (val > $signed({2'b00, rqy_pkg::ChromaMax})) begin
        finish = rqy_pkg::ChromaMax;
      end else begin
        finish = val[7:0];
      end
    end
  endfunction

  assign cb_d = finish(cb_num_q);
  assign cr_d = finish(cr_num_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      ravg_q <= rsum[9:2];
      gavg_q <= gsum[9:2];
      bavg_q <= bsum[9:2];
    end
    if (en_i.s2) begin
      cb_num_q <= cb_full[15:0];
      cr_num_q <= cr_full[15:0];
    end
    if (en_i.s3) begin
      cb_q <= cb_d;
      cr_q <= cr_d;
    end
  end

  assign chroma_blue_o = cb_q;
  assign chroma_red_o  = cr_q;

endmodule

`default_nettype wire

// ===== src/rgb_quad_to_yuv420_bt601.sv =====
// rgb to yuv 4:2:0 converter, bt.601 limited range, one 2x2 pixel block per transfer
// quad_i (sink): valid/ready channel carrying twelve 8-bit rgb components of a block
// yuv_o (source): valid/ready channel carrying four luma samples and one cb/cr pair
// a transfer happens on a rising clk_i edge with valid and ready both high
// three register stages: weighted sums and channel averages, luma clamp and
//   chroma numerators, chroma division and clamp into the output register
// path: each block passes the stage one, two and three registers on its way to yuv_o
// throughput: one block per cycle without stalls, set by the three-stage pipeline;
//   every stage has its own valid bit and loads whenever it is empty or moving on
// receiver stall: the output register holds its result, the stages behind it
//   keep filling bubbles, and quad_i.ready falls only once all three are full;
//   quad_i.ready comes from the stage valid bits and yuv_o.ready, never from
//   quad_i.valid
// reset (rst_ni low, asynchronous): all valid bits clear, the pipeline is empty
//   and no result is shown; data registers are not reset
`default_nettype none

module rgb_quad_to_yuv420_bt601 (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rqy_quad_if.sink    quad_i,
  rqy_yuv_if.source   yuv_o
);

  logic               v1_q, v2_q, v3_q;
  logic               rdy1, rdy2, rdy3;
  rqy_pkg::stage_en_t en;
  rqy_pkg::quad_t     quad;
  rqy_pkg::yuv_t      yuv;

  // a stage can take new data when empty or when its content moves on
  assign rdy3 = !v3_q || yuv_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  assign quad_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= quad_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  assign quad = quad_i.data;

  // one luma lane per pixel
  rqy_luma_lane u_luma_tl (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (quad.red_top_left),
    .green_i (quad.green_top_left),
    .blue_i  (quad.blue_top_left),
    .luma_o  (yuv.luma_top_left)
  );

  rqy_luma_lane u_luma_tr (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (quad.red_top_right),
    .green_i (quad.green_top_right),
    .blue_i  (quad.blue_top_right),
    .luma_o  (yuv.luma_top_right)
  );

  rqy_luma_lane u_luma_bl (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (quad.red_bottom_left),
    .green_i (quad.green_bottom_left),
    .blue_i  (quad.blue_bottom_left),
    .luma_o  (yuv.luma_bottom_left)
  );

  rqy_luma_lane u_luma_br (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (quad.red_bottom_right),
    .green_i (quad.green_bottom_right),
    .blue_i  (quad.blue_bottom_right),
    .luma_o  (yuv.luma_bottom_right)
  );

  // shared chroma from the block average
  rqy_chroma u_chroma (
    .clk_i         (clk_i),
    .en_i          (en),
    .quad_i        (quad),
    .chroma_blue_o (yuv.chroma_blue),
    .chroma_red_o  (yuv.chroma_red)
  );

  assign yuv_o.valid = v3_q;
  assign yuv_o.data  = yuv;

endmodule

`default_nettype wire

// ===== sim/rgb_quad_to_yuv420_bt601_tb.sv =====
module rgb_quad_to_yuv420_bt601_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int unsigned RandomBlocks  = 950;
  localparam int unsigned PressureBurst = 80;   // gap-free burst that meets the long stall
  localparam int unsigned HoldOffCycles = 60;   // long receiver stall, fills the pipeline
  localparam int unsigned DrainCycles   = 10;   // margin after the last owed result, catches strays
  localparam int unsigned YuvFields     = 6;
  localparam int unsigned YuvW          = $bits(rqy_pkg::yuv_t);
  localparam int unsigned CompW         = rqy_pkg::CompW;

  // kinds of random pixel block
  typedef enum int unsigned {
    BlockUniform,   // every component independent
    BlockFlat,      // one random colour over all four pixels
    BlockExtreme,   // every component either 0 or 255
    BlockDim        // tiny values, chroma numerators near zero
  } block_kind_e;

  // receiver stall patterns
  typedef enum int unsigned {
    ReadyAlways,
    ReadyCoin,
    ReadyMostly,
    ReadyThird,
    ReadyScarce
  } ready_kind_e;

  // expectation attached to a block when it is offered: a pinned value or the predictor
  typedef struct packed {
    logic          pinned;
    rqy_pkg::yuv_t yuv;
  } yuv_plan_t;

  typedef struct packed {
    logic           pinned;
    rqy_pkg::quad_t blk;
    rqy_pkg::yuv_t  yuv;
  } block_row_t;

  logic clk_i;
  logic rst_ni;

  rqy_quad_if quad_bus ();
  rqy_yuv_if  yuv_bus ();

  rgb_quad_to_yuv420_bt601 DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quad_i (quad_bus),
    .yuv_o  (yuv_bus)
  );

  // blocks offered but not yet transferred, then results still owed by the block
  yuv_plan_t     offered_plan [$];
  rqy_pkg::yuv_t pending_yuv  [$];
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left     = 0;
  bit            hold_off_req   = 1'b0;

  string field_names [YuvFields] = '{
    "luma_top_left", "luma_top_right", "luma_bottom_left", "luma_bottom_right",
    "chroma_blue", "chroma_red"
  };

  // directed blocks, pixels in the order top left, top right, bottom left, bottom right,
  // each pixel written as 24'hRRGGBB; only black and white carry a typed-in result
  block_row_t directed_rows [18] = '{
    // black: lowest luma, neutral chroma
    '{1'b1, {4{24'h000000}},
      {8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128}},
    // white: highest luma, chroma weights cancel
    '{1'b1, {4{24'hFFFFFF}},
      {8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128}},
    // primaries and secondaries, chroma at its extremes both ways
    '{1'b0, {4{24'hFF0000}}, 48'd0},
    '{1'b0, {4{24'h00FF00}}, 48'd0},
    '{1'b0, {4{24'h0000FF}}, 48'd0},
    '{1'b0, {4{24'h00FFFF}}, 48'd0},
    '{1'b0, {4{24'hFF00FF}}, 48'd0},
    '{1'b0, {4{24'hFFFF00}}, 48'd0},
    // checkerboard, luma per pixel differs from the average
    '{1'b0, {24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF}, 48'd0},
    // a primary in three pixels and white in the fourth, every luma different
    '{1'b0, {24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF}, 48'd0},
    // faint red: cb numerator slightly negative, must truncate to zero not minus one
    '{1'b0, {4{24'h040000}}, 48'd0},
    // faint green: both chroma numerators slightly negative
    '{1'b0, {4{24'h000200}}, 48'd0},
    // average remainder dropped: sums of 3 average to 0
    '{1'b0, {24'h000000, 24'h000000, 24'h000000, 24'h030303}, 48'd0},
    // sums just under a multiple of four
    '{1'b0, {24'hFEFEFE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 48'd0},
    // alternating bit patterns
    '{1'b0, {4{24'hAA55AA}}, 48'd0},
    '{1'b0, {24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA}, 48'd0},
    // lone bright pixel in a dark block
    '{1'b0, {24'h00FF00, 24'h000000, 24'h000000, 24'h000000}, 48'd0},
    // uneven blue, average of 191
    '{1'b0, {24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h000000}, 48'd0}
  };

  function automatic int limit_to(input int value, input int lo, input int hi);
    if (value < lo) return lo;
    if (value > hi) return hi;
    return value;
  endfunction

  // bt.601 limited range: luma per pixel, chroma from the truncated block average,
  // signed numerators with division truncating toward zero
  function automatic rqy_pkg::yuv_t bt601_convert(input rqy_pkg::quad_t blk);
    int            red, green, blue;
    int            red_sum, green_sum, blue_sum;
    int            chroma_b, chroma_r;
    rqy_pkg::yuv_t res;
    red_sum   = 0;
    green_sum = 0;
    blue_sum  = 0;
    for (int p = 0; p < 4; p++) begin
      red   = int'(blk[95 - 24*p -: CompW]);
      green = int'(blk[87 - 24*p -: CompW]);
      blue  = int'(blk[79 - 24*p -: CompW]);
      red_sum   += red;
      green_sum += green;
      blue_sum  += blue;
      res[YuvW - 1 - CompW*p -: CompW] = rqy_pkg::comp_t'(limit_to(
          (66*red + 129*green + 25*blue + 128) / 256 + 16,
          int'(rqy_pkg::LumaMin), int'(rqy_pkg::LumaMax)));
    end
    red   = red_sum / 4;
    green = green_sum / 4;
    blue  = blue_sum / 4;
    chroma_b = (-38*red - 74*green + 112*blue + 128) / 256 + 128;
    chroma_r = (112*red - 94*green - 18*blue + 128) / 256 + 128;
    res.chroma_blue = rqy_pkg::comp_t'(limit_to(chroma_b,
        int'(rqy_pkg::ChromaMin), int'(rqy_pkg::ChromaMax)));
    res.chroma_red  = rqy_pkg::comp_t'(limit_to(chroma_r,
        int'(rqy_pkg::ChromaMin), int'(rqy_pkg::ChromaMax)));
    return res;
  endfunction

  function automatic rqy_pkg::quad_t random_block();
    block_kind_e    kind;
    logic [23:0]    colour;
    rqy_pkg::quad_t blk;
    kind   = block_kind_e'($urandom_range(0, 3));
    colour = 24'($urandom);
    for (int c = 0; c < 12; c++) begin
      case (kind)
        BlockUniform: blk[95 - CompW*c -: CompW] = rqy_pkg::comp_t'($urandom);
        BlockFlat:    blk[95 - CompW*c -: CompW] = colour[23 - CompW*(c % 3) -: CompW];
        BlockExtreme: blk[95 - CompW*c -: CompW] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default:      blk[95 - CompW*c -: CompW] = rqy_pkg::comp_t'($urandom_range(0, 7));
      endcase
    end
    return blk;
  endfunction

  // hold valid and data until the transfer happens
  task automatic offer_block(input rqy_pkg::quad_t blk, input logic pinned,
                             input rqy_pkg::yuv_t yuv);
    yuv_plan_t plan;
    plan.pinned  = pinned;
    plan.yuv     = yuv;
    offered_plan = {offered_plan, plan};
    quad_bus.valid <= 1'b1;
    quad_bus.data  <= blk;
    do @(posedge clk_i); while (!quad_bus.ready);
  endtask

  // sender bursts: stay valid inside a burst, drop valid for a random gap between bursts
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      quad_bus.valid <= 1'b0;
      quad_bus.data  <= rqy_pkg::quad_t'({$urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 47);
    end
  endtask

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : reset_gen
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender: directed table, then random blocks, then drain and verdict
  initial begin : feed_side
    quad_bus.valid <= 1'b0;
    quad_bus.data  <= '0;
    wait (rst_ni);
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_block(directed_rows[i].blk, directed_rows[i].pinned, directed_rows[i].yuv);
      pace();
    end

    // first random burst runs without gaps while the receiver holds off
    burst_left   = PressureBurst;
    hold_off_req = 1'b1;
    repeat (RandomBlocks) begin
      offer_block(random_block(), 1'b0, '0);
      pace();
    end
    quad_bus.valid <= 1'b0;

    // wait for every owed result, then the DrainCycles margin to catch strays
    while (offered_plan.size() != 0 || pending_yuv.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: stall patterns in random spans, one long hold-off on request
  initial begin : drain_side
    ready_kind_e kind;
    int unsigned span;
    int unsigned tick;
    yuv_bus.ready <= 1'b0;
    tick = 0;
    wait (rst_ni);
    forever begin
      kind = ready_kind_e'($urandom_range(0, 4));
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          yuv_bus.ready <= 1'b0;
          repeat (HoldOffCycles) @(posedge clk_i);
        end
        case (kind)
          ReadyAlways: yuv_bus.ready <= 1'b1;
          ReadyCoin:   yuv_bus.ready <= 1'($urandom_range(0, 1));
          ReadyMostly: yuv_bus.ready <= ($urandom_range(0, 4) != 0);
          ReadyThird:  yuv_bus.ready <= ((tick % 3) != 0);
          default:     yuv_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // both transfers sampled at the edge, before any driver update of this step
  always @(posedge clk_i) begin : scoreboard
    yuv_plan_t     plan;
    rqy_pkg::yuv_t want;
    if (rst_ni) begin
      if (quad_bus.valid && quad_bus.ready) begin
        plan = offered_plan.pop_front();
        want = plan.pinned ? plan.yuv : bt601_convert(quad_bus.data);
        pending_yuv = {pending_yuv, want};
      end
      if (yuv_bus.valid && yuv_bus.ready) begin
        if (pending_yuv.size() == 0) begin
          $error("yuv transfer with no block outstanding: %h", yuv_bus.data);
          mismatch_count++;
        end else begin
          want = pending_yuv.pop_front();
          for (int f = 0; f < YuvFields; f++) begin
            if (yuv_bus.data[YuvW - 1 - CompW*f -: CompW] !== want[YuvW - 1 - CompW*f -: CompW])
            begin
              $error("%s: expected %0d, actual %0d", field_names[f],
                     want[YuvW - 1 - CompW*f -: CompW],
                     yuv_bus.data[YuvW - 1 - CompW*f -: CompW]);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  // generous ceiling, far above the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
